FILE: sv/bta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_pkg
// shared types and constants of the batch throughput averager
// ----------------------------------------------------------------------------
package bta_pkg;

	localparam int RATE_W = 24;
	localparam int REG_W = 32;
	localparam logic [23:0] RATE_MAX = 24'hFFFFFF;
	localparam logic [17:0] LB_PER_KG_Q16 = 18'd144482;

	typedef enum logic [1:0] {
		CFG_WINDOW  = 2'd0,
		CFG_LIQ_ACT = 2'd1,
		CFG_LIQ_RATE = 2'd2,
		CFG_DISPLAY = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic        hold;
		logic        first_batch;
		logic        auto_mode;
		logic        startup;
		logic [19:0] batch_weight;
		logic [15:0] whole_seconds;
		logic [9:0]  tick_fraction;
	} in_item_t;

	typedef struct packed {
		logic        updated;
		logic [23:0] batch_rate;
		logic [23:0] batch_rate_lb;
		logic [23:0] average_rate;
		logic [23:0] average_rate_lb;
		logic [31:0] register_value;
	} out_item_t;

endpackage

FILE: sv/bta_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_stream_if
// valid/ready channel carrying one item
// ----------------------------------------------------------------------------
interface bta_stream_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/bta_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_ram
// generic single port ram, registered read
// ----------------------------------------------------------------------------
module bta_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: sv/bta_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bta_divider #(
	parameter int NW = 64,
	parameter int DW = 40
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;

	assign trial = {rem_q[DW-1:0], quo_q[NW-1]};
	assign quo = quo_q;
	assign done = busy_q && (cnt_q == CW'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			den_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(NW);
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (cnt_q == CW'(0)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CW'(1);
				if (trial >= {1'b0, den_q}) begin
					rem_q <= trial - {1'b0, den_q};
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
			end
		end
	end
endmodule

FILE: sv/batch_throughput_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batch_throughput_averager
// batch rate from weight and time, ring average, lb/h and display values
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_ch    in   hold, first_batch, auto_mode, startup, weight, seconds, ticks
// out_ch   out  updated, rates, averages, register value
// cfg      in   cfg_we, cfg_index, cfg_data
//
// an item passes a bit-serial rate division, a ring walk of one ram read per
// cycle over the filled entries and a bit-serial average division, which an
// empty ring after the update skips; a held item goes straight to the output.
// after reset a clearing pass over MAX_WINDOW addresses zeroes the ring ram.
// input is taken only in idle; a finished item waits in its last state while
// the previous result still sits unaccepted in the output register.
// ----------------------------------------------------------------------------
module batch_throughput_averager #(
	parameter int TICKS_PER_SECOND = 1024,
	parameter int MAX_WINDOW = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bta_stream_if.sink            in_ch,
	bta_stream_if.source          out_ch,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [23:0]           cfg_data
);
	import bta_pkg::*;

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int TW = 16 + $clog2(TICKS_PER_SECOND + 1) + 2;
	localparam int NW = 64;
	localparam int SW = RATE_W + CW;
	localparam int SHORT_TICKS = TICKS_PER_SECOND / 10;
	localparam logic [5:0] WMAX6 = (MAX_WINDOW > 63) ? 6'd63 : 6'(MAX_WINDOW);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_RDIV, ST_RATE, ST_RING, ST_SUM, ST_ASTART, ST_ADIV,
		ST_OUT
	} state_t;

	state_t state_q;
	logic [5:0]  window_q;
	logic        liq_act_q;
	logic [23:0] liq_rate_q;
	logic [19:0] disp_q;
	logic [9:0]  prev_tick_q;
	logic [5:0]  last_win_q;
	logic [AW-1:0] wr_idx_q;
	logic [CW-1:0] fill_q;
	logic [AW:0]   sweep_q;
	in_item_t    item_q;
	logic signed [TW-1:0] ticks_q;
	logic [23:0] rate_q, avg_q;
	logic [SW-1:0] sum_q;
	out_item_t   out_q;
	logic        out_valid_q;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [23:0]   ram_wdata, ram_rdata;
	logic          div_start, div_done;
	logic [NW-1:0] div_num, div_quo;
	logic [TW-1:0] div_den;
	in_item_t      in_item;

	logic [23:0]   rate_sat, rate_liq;
	logic [24:0]   rate_sum;
	logic          clr;
	logic [CW-1:0] win_c;
	logic [AW-1:0] wr_base;
	logic [CW-1:0] fill_base, fill_next;
	logic [AW:0]   wr_next;
	logic signed [TW-1:0] ticks_c;
	logic [41:0]   brate_p, arate_p;
	logic [44:0]   reg_p;
	logic [23:0]   brate_lb, arate_lb;
	logic          out_load;
	out_item_t     out_c;

	assign in_item = in_item_t'(in_ch.data);
	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	bta_ram #(.WIDTH(24), .DEPTH(1 << AW)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	bta_divider #(.NW(NW), .DW(TW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	assign ticks_c = $signed(TW'(in_item.whole_seconds) * TW'(TICKS_PER_SECOND)
		+ TW'(TICKS_PER_SECOND) + TW'(in_item.tick_fraction) - TW'(prev_tick_q));

	assign rate_sat = (div_quo > NW'(RATE_MAX)) ? RATE_MAX : div_quo[23:0];
	assign rate_sum = {1'b0, rate_q} + {1'b0, liq_rate_q};
	assign rate_liq = rate_sum[24] ? RATE_MAX : rate_sum[23:0];
	assign clr = (item_q.auto_mode && item_q.startup) || (window_q != last_win_q);
	assign win_c = (window_q == 6'd0) ? CW'(1) :
		(window_q > WMAX6) ? CW'(MAX_WINDOW) : CW'(window_q);
	// ring pointers as seen after a possible clear
	assign wr_base = clr ? '0 : wr_idx_q;
	assign fill_base = clr ? '0 : fill_q;
	assign wr_next = {1'b0, wr_base} + (AW+1)'(1);
	assign fill_next = (fill_base < win_c) ? fill_base + CW'(1) : fill_base;

	assign brate_p = 42'(rate_q) * 42'(LB_PER_KG_Q16);
	assign arate_p = 42'(avg_q) * 42'(LB_PER_KG_Q16);
	assign reg_p = 45'(avg_q) * 45'(disp_q) + 45'(32768);
	assign brate_lb = (brate_p[41:40] != 2'b00) ? RATE_MAX : brate_p[39:16];
	assign arate_lb = (arate_p[41:40] != 2'b00) ? RATE_MAX : arate_p[39:16];

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);

	always_comb begin
		out_c = '0;
		if (!item_q.hold) begin
			out_c.updated = 1'b1;
			out_c.batch_rate = rate_q;
			out_c.batch_rate_lb = brate_lb;
			out_c.average_rate = avg_q;
			out_c.average_rate_lb = arate_lb;
			out_c.register_value = {3'b000, reg_p[44:16]};
		end
	end

	always_comb begin
		ram_we = 1'b0;
		ram_addr = sweep_q[AW-1:0];
		ram_wdata = '0;
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				div_start = in_ch.valid && !in_item.hold;
				div_num = NW'(in_item.batch_weight) * NW'(36 * TICKS_PER_SECOND);
				div_den = $unsigned(ticks_c);
			end
			ST_RING: begin
				ram_we = !item_q.first_batch;
				ram_addr = wr_base;
				ram_wdata = rate_q;
			end
			ST_ASTART: begin
				div_start = 1'b1;
				div_num = NW'(sum_q);
				div_den = TW'(fill_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			window_q <= 6'd4;
			liq_act_q <= 1'b0;
			liq_rate_q <= '0;
			disp_q <= 20'd65536;
			prev_tick_q <= '0;
			last_win_q <= '0;
			wr_idx_q <= '0;
			fill_q <= '0;
			sweep_q <= '0;
			item_q <= '0;
			ticks_q <= '0;
			rate_q <= '0;
			avg_q <= '0;
			sum_q <= '0;
			out_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_WINDOW:   window_q <= cfg_data[5:0];
					CFG_LIQ_ACT:  liq_act_q <= cfg_data[0];
					CFG_LIQ_RATE: liq_rate_q <= cfg_data[23:0];
					CFG_DISPLAY:  disp_q <= cfg_data[19:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_q <= out_c;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + (AW+1)'(1);
					if (sweep_q[AW-1:0] == AW'(MAX_WINDOW - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_ch.valid) begin
						item_q <= in_item;
						ticks_q <= ticks_c;
						prev_tick_q <= in_item.tick_fraction;
						state_q <= in_item.hold ? ST_OUT : ST_RDIV;
					end
				end
				ST_RDIV: begin
					if (div_done) begin
						// batches of 0.1 s or less give no rate
						rate_q <= (ticks_q > $signed(TW'(SHORT_TICKS))) ? rate_sat : '0;
						state_q <= ST_RATE;
					end
				end
				ST_RATE: begin
					if (liq_act_q) begin
						rate_q <= rate_liq;
					end
					state_q <= ST_RING;
				end
				ST_RING: begin
					last_win_q <= window_q;
					if (!item_q.first_batch) begin
						wr_idx_q <= (wr_next >= (AW+1)'(win_c)) ? '0 : wr_next[AW-1:0];
						fill_q <= fill_next;
					end else begin
						wr_idx_q <= wr_base;
						fill_q <= fill_base;
					end
					sweep_q <= '0;
					sum_q <= '0;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					// issue reads 0..fill-1, accumulate each result in the cycle after its read
					if (sweep_q != '0) begin
						sum_q <= sum_q + SW'(ram_rdata);
					end
					sweep_q <= sweep_q + (AW+1)'(1);
					if (sweep_q == (AW+1)'(fill_q)) begin
						avg_q <= '0;
						state_q <= (fill_q == '0) ? ST_OUT : ST_ASTART;
					end
				end
				ST_ASTART: begin
					state_q <= ST_ADIV;
				end
				ST_ADIV: begin
					if (div_done) begin
						avg_q <= rate_sat;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
